FILE: rtl/glsi_pkg.sv
`timescale 1ns / 1ps

package glsi_pkg;

   // Request fields: one control pass
   typedef struct packed {
      logic [15:0]        elapsed_ms;
      logic               gas_valid;
      logic [11:0]        gas_sample;
      logic               temp_valid;
      logic signed [7:0]  temp_sample;
      logic               button_down;
      logic [2:0]         command;
   } req_payload_type;

   // Result fields: levels after the pass plus event reporting
   typedef struct packed {
      logic        valve_shut;
      logic        fan_on;
      logic        buzzer_on;
      logic        cooking_now;
      logic [2:0]  gas_event;
      logic        command_shutoff;
      logic [2:0]  beep_count;
      logic        button_toggled;
      logic [11:0] threshold_in_use;
   } rsp_payload_type;

   // Remote command codes
   localparam logic [2:0] CMD_NONE       = 3'd0;
   localparam logic [2:0] CMD_EMERG_STOP = 3'd1;
   localparam logic [2:0] CMD_TOGGLE     = 3'd2;
   localparam logic [2:0] CMD_VALVE_OPEN = 3'd3;
   localparam logic [2:0] CMD_VALVE_SHUT = 3'd4;

   // Gas event codes
   localparam logic [2:0] EVT_NONE     = 3'd0;
   localparam logic [2:0] EVT_LEAK     = 3'd1;
   localparam logic [2:0] EVT_NORMAL   = 3'd2;
   localparam logic [2:0] EVT_SHUTOFF  = 3'd3;
   localparam logic [2:0] EVT_COOK_EMG = 3'd4;

   // Configuration register indexes
   localparam logic [2:0] REG_NORMAL_THR = 3'd0;
   localparam logic [2:0] REG_HIGH_THR   = 3'd1;
   localparam logic [2:0] REG_HOT_THR    = 3'd2;
   localparam logic [2:0] REG_COLD_THR   = 3'd3;
   localparam logic [2:0] REG_HOT_LIMIT  = 3'd4;
   localparam logic [2:0] REG_COLD_LIMIT = 3'd5;
   localparam logic [2:0] REG_ALARM_DLY  = 3'd6;

   // Reset values of the configuration registers
   localparam logic [11:0]       NORMAL_THR_RST = 12'd1000;
   localparam logic [11:0]       HIGH_THR_RST   = 12'd3000;
   localparam logic [11:0]       HOT_THR_RST    = 12'd1000;
   localparam logic [11:0]       COLD_THR_RST   = 12'd1000;
   localparam logic signed [7:0] HOT_LIMIT_RST  = 8'sd35;
   localparam logic signed [7:0] COLD_LIMIT_RST = 8'sd15;
   localparam logic [15:0]       ALARM_DLY_RST  = 16'd2000;

   // Timing constants in milliseconds
   localparam logic [15:0] DEBOUNCE_MS    = 16'd300;
   localparam logic [15:0] BEEP_PERIOD_MS = 16'd3000;

   // Beep counts per reason
   localparam logic [2:0] BEEPS_TOGGLE = 3'd1;
   localparam logic [2:0] BEEPS_LEAK   = 3'd3;
   localparam logic [2:0] BEEPS_COOK   = 3'd2;

   // Add elapsed time to an age, saturating at full scale
   function automatic logic [15:0] age_add(input logic [15:0] age, input logic [15:0] dt);
      logic [16:0] sum;
      sum = {1'b0, age} + {1'b0, dt};
      return sum[16] ? 16'hFFFF : sum[15:0];
   endfunction

endpackage

FILE: rtl/gas_leak_safety_interlock.sv
`timescale 1ns / 1ps

// Channel   Ports                                  Direction  Moves
// request   req_valid, req_ready, req_data         in         one control pass
// response  rsp_valid, rsp_ready, rsp_data         out        levels and events of the pass
// csr       csr_write_en, csr_index, csr_wdata     in         threshold, limit and delay registers
//
// One pass per cycle sustained while the response is taken; a request goes through the
// input register, then the state update and response register.
// Synchronous active-high reset returns control state, configuration registers and valid flags to defaults.
// A stalled response holds the input register; the input register refills in
// the same cycle its request moves on, so the block keeps full rate.
module gas_leak_safety_interlock (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  glsi_pkg::req_payload_type req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output glsi_pkg::rsp_payload_type rsp_data,
   input  logic                      csr_write_en,
   input  logic [2:0]                csr_index,
   input  logic [15:0]               csr_wdata
);
   import glsi_pkg::*;

   // Configuration registers
   logic [11:0]       normal_thr_ff, high_thr_ff, hot_thr_ff, cold_thr_ff;
   logic signed [7:0] hot_limit_ff, cold_limit_ff;
   logic [15:0]       alarm_dly_ff;

   // Pipeline registers
   logic            req_vld_ff;
   req_payload_type req_ff;
   logic            rsp_vld_ff;
   rsp_payload_type rsp_ff;

   // Control state
   logic        cooking_ff, alert_ff, held_ff, valve_ff, fan_ff, buzzer_ff;
   logic [11:0] last_gas_ff, thr_ff;
   logic [15:0] alert_age_ff, deb_age_ff, beep_age_ff;

   // Next values
   logic        cooking_in, alert_in, held_in, valve_in, fan_in, buzzer_in;
   logic [11:0] last_gas_in, thr_in;
   logic [15:0] alert_age_in, deb_age_in, beep_age_in;
   rsp_payload_type rsp_in;

   logic advance;
   logic toggle;

   assign advance   = req_vld_ff && (!rsp_vld_ff || rsp_ready);
   assign req_ready = !req_vld_ff || advance;
   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_ff;

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         normal_thr_ff <= NORMAL_THR_RST;
         high_thr_ff   <= HIGH_THR_RST;
         hot_thr_ff    <= HOT_THR_RST;
         cold_thr_ff   <= COLD_THR_RST;
         hot_limit_ff  <= HOT_LIMIT_RST;
         cold_limit_ff <= COLD_LIMIT_RST;
         alarm_dly_ff  <= ALARM_DLY_RST;
      end else if (csr_write_en) begin
         unique case (csr_index)
            REG_NORMAL_THR: normal_thr_ff <= csr_wdata[11:0];
            REG_HIGH_THR:   high_thr_ff   <= csr_wdata[11:0];
            REG_HOT_THR:    hot_thr_ff    <= csr_wdata[11:0];
            REG_COLD_THR:   cold_thr_ff   <= csr_wdata[11:0];
            REG_HOT_LIMIT:  hot_limit_ff  <= csr_wdata[7:0];
            REG_COLD_LIMIT: cold_limit_ff <= csr_wdata[7:0];
            REG_ALARM_DLY:  alarm_dly_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Capture the request
   always_ff @(posedge clock) begin
      if (reset) begin
         req_vld_ff <= 1'b0;
      end else if (req_ready) begin
         req_vld_ff <= req_valid;
      end
      if (req_ready && req_valid) begin
         req_ff <= req_data;
      end
   end

   // Compute one control pass
   always_comb begin
      rsp_in = '0;
      toggle = 1'b0;

      // Advance ages
      alert_age_in = age_add(alert_age_ff, req_ff.elapsed_ms);
      deb_age_in   = age_add(deb_age_ff, req_ff.elapsed_ms);
      beep_age_in  = age_add(beep_age_ff, req_ff.elapsed_ms);

      cooking_in  = cooking_ff;
      alert_in    = alert_ff;
      held_in     = held_ff;
      valve_in    = valve_ff;
      fan_in      = fan_ff;
      buzzer_in   = buzzer_ff;
      last_gas_in = last_gas_ff;
      thr_in      = thr_ff;

      // Apply the remote command
      unique case (req_ff.command)
         CMD_EMERG_STOP: begin
            buzzer_in = 1'b1;
            valve_in  = 1'b1;
            fan_in    = 1'b1;
            rsp_in.command_shutoff = 1'b1;
         end
         CMD_TOGGLE:     cooking_in = !cooking_in;
         CMD_VALVE_OPEN: valve_in   = 1'b0;
         CMD_VALVE_SHUT: valve_in   = 1'b1;
         default: ;
      endcase

      // Take samples and pick the threshold
      if (req_ff.gas_valid) begin
         last_gas_in = req_ff.gas_sample;
      end
      if (req_ff.temp_valid) begin
         priority if (req_ff.temp_sample > hot_limit_ff) begin
            thr_in = hot_thr_ff;
         end else if (req_ff.temp_sample < cold_limit_ff) begin
            thr_in = cold_thr_ff;
         end else begin
            thr_in = normal_thr_ff;
         end
      end

      // Debounced button toggles the mode
      toggle = req_ff.button_down && !held_ff && (deb_age_in > DEBOUNCE_MS);
      if (toggle) begin
         held_in    = 1'b1;
         deb_age_in = '0;
         cooking_in = !cooking_in;
         rsp_in.beep_count = rsp_in.beep_count + BEEPS_TOGGLE;
         buzzer_in  = 1'b0;
         rsp_in.button_toggled = 1'b1;
         if (!cooking_in) begin
            fan_in   = 1'b0;
            valve_in = 1'b0;
         end
      end else if (!req_ff.button_down) begin
         held_in = 1'b0;
      end

      // Gas logic
      if (!cooking_in) begin
         if (last_gas_in > thr_in) begin
            if (!alert_ff) begin
               alert_in     = 1'b1;
               alert_age_in = '0;
               rsp_in.gas_event  = EVT_LEAK;
               rsp_in.beep_count = rsp_in.beep_count + BEEPS_LEAK;
               buzzer_in    = 1'b0;
            end
            if (alert_age_in > alarm_dly_ff) begin
               buzzer_in = 1'b1;
               valve_in  = 1'b1;
               fan_in    = 1'b1;
               rsp_in.gas_event = EVT_SHUTOFF;
            end
         end else if (alert_ff) begin
            alert_in  = 1'b0;
            rsp_in.gas_event = EVT_NORMAL;
            buzzer_in = 1'b0;
            valve_in  = 1'b0;
            fan_in    = 1'b0;
         end
      end else begin
         priority if (last_gas_in < normal_thr_ff) begin
            fan_in    = 1'b0;
            buzzer_in = 1'b0;
         end else if (last_gas_in < high_thr_ff) begin
            fan_in = 1'b1;
            if (beep_age_in > BEEP_PERIOD_MS) begin
               rsp_in.beep_count = rsp_in.beep_count + BEEPS_COOK;
               buzzer_in   = 1'b0;
               beep_age_in = '0;
            end
         end else begin
            cooking_in = 1'b0;
            buzzer_in  = 1'b1;
            valve_in   = 1'b1;
            fan_in     = 1'b1;
            rsp_in.gas_event = EVT_COOK_EMG;
         end
      end

      rsp_in.valve_shut       = valve_in;
      rsp_in.fan_on           = fan_in;
      rsp_in.buzzer_on        = buzzer_in;
      rsp_in.cooking_now      = cooking_in;
      rsp_in.threshold_in_use = thr_in;
   end

   // Commit state on each pass
   always_ff @(posedge clock) begin
      if (reset) begin
         cooking_ff   <= 1'b0;
         alert_ff     <= 1'b0;
         held_ff      <= 1'b0;
         valve_ff     <= 1'b0;
         fan_ff       <= 1'b0;
         buzzer_ff    <= 1'b0;
         last_gas_ff  <= '0;
         thr_ff       <= NORMAL_THR_RST;
         alert_age_ff <= '0;
         deb_age_ff   <= '0;
         beep_age_ff  <= '0;
      end else if (advance) begin
         cooking_ff   <= cooking_in;
         alert_ff     <= alert_in;
         held_ff      <= held_in;
         valve_ff     <= valve_in;
         fan_ff       <= fan_in;
         buzzer_ff    <= buzzer_in;
         last_gas_ff  <= last_gas_in;
         thr_ff       <= thr_in;
         alert_age_ff <= alert_age_in;
         deb_age_ff   <= deb_age_in;
         beep_age_ff  <= beep_age_in;
      end
   end

   // Hold or load the response
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (advance) begin
         rsp_vld_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_vld_ff <= 1'b0;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

FILE: test/gas_leak_safety_interlock_test.sv
`timescale 1ns / 1ps

module gas_leak_safety_interlock_test;
   import glsi_pkg::*;

   localparam int WATCHDOG_LIMIT   = 4000;
   localparam int HOLD_CYCLES      = 80;
   localparam int RANDOM_PER_PHASE = 80;
   localparam int MAX_REPORTS      = 10;

   logic            clock        = 1'b0;
   logic            reset        = 1'b1;
   logic            req_valid    = 1'b0;
   logic            req_ready;
   req_payload_type req_data     = '0;
   logic            rsp_valid;
   logic            rsp_ready    = 1'b0;
   rsp_payload_type rsp_data;
   logic            csr_write_en = 1'b0;
   logic [2:0]      csr_index    = REG_NORMAL_THR;
   logic [15:0]     csr_wdata    = '0;

   // Idle rates in percent and the long receiver stall requests
   int req_idle_pct = 29;
   int rsp_idle_pct = 29;
   int holds_asked  = 0;
   int holds_served = 0;
   int hold_left    = 0;

   // Stimulus state that keeps gas level and button level from jumping every pass
   logic [11:0] gas_target = '0;
   logic        btn_level = 1'b0;

   // Register copy used for prediction
   logic [11:0]        normal_thr, high_thr, hot_thr, cold_thr;
   logic signed [7:0]  hot_lim, cold_lim;
   logic [15:0]        alarm_dly;

   // Interlock state copy
   logic        cooking, alerted, btn_held, valve, fan, buzzer;
   logic [11:0] last_gas, active_thr;
   logic [15:0] alert_age, debounce_age, beep_age;

   rsp_payload_type expected_passes[$];

   int fail_count    = 0;
   int passes_sent   = 0;
   int results_seen  = 0;
   int leaks_seen    = 0;
   int shutoffs_seen = 0;
   int cook_emg_seen = 0;
   int toggles_seen  = 0;
   int settings_used = 0;
   int quiet_cycles  = 0;

   gas_leak_safety_interlock dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // ---------------------------------------------------------------- predictor

   function automatic logic [15:0] aged(input logic [15:0] age, input logic [15:0] dt);
      logic [16:0] total;
      total = {1'b0, age} + {1'b0, dt};
      return (total > 17'h0FFFF) ? 16'hFFFF : total[15:0];
   endfunction

   task automatic reset_interlock_model();
      normal_thr   = NORMAL_THR_RST;
      high_thr     = HIGH_THR_RST;
      hot_thr      = HOT_THR_RST;
      cold_thr     = COLD_THR_RST;
      hot_lim      = HOT_LIMIT_RST;
      cold_lim     = COLD_LIMIT_RST;
      alarm_dly    = ALARM_DLY_RST;
      cooking      = 1'b0;
      alerted      = 1'b0;
      btn_held     = 1'b0;
      valve        = 1'b0;
      fan          = 1'b0;
      buzzer       = 1'b0;
      last_gas     = '0;
      active_thr   = NORMAL_THR_RST;
      alert_age    = '0;
      debounce_age = '0;
      beep_age     = '0;
   endtask

   task automatic trip_shutoff();
      buzzer = 1'b1;
      valve  = 1'b1;
      fan    = 1'b1;
   endtask

   // Work out the result of one control pass and advance the state copy
   task automatic advance_interlock(input req_payload_type pass,
                                    output rsp_payload_type outcome);
      outcome      = '0;
      alert_age    = aged(alert_age, pass.elapsed_ms);
      debounce_age = aged(debounce_age, pass.elapsed_ms);
      beep_age     = aged(beep_age, pass.elapsed_ms);

      // remote command first
      case (pass.command)
         CMD_EMERG_STOP: begin
            trip_shutoff();
            outcome.command_shutoff = 1'b1;
         end
         CMD_TOGGLE:     cooking = ~cooking;
         CMD_VALVE_OPEN: valve = 1'b0;
         CMD_VALVE_SHUT: valve = 1'b1;
         default: ;
      endcase

      // take samples; temperature picks the threshold
      if (pass.gas_valid)
         last_gas = pass.gas_sample;
      if (pass.temp_valid) begin
         if ($signed(pass.temp_sample) > hot_lim)
            active_thr = hot_thr;
         else if ($signed(pass.temp_sample) < cold_lim)
            active_thr = cold_thr;
         else
            active_thr = normal_thr;
      end

      // debounced press flips the mode; leaving cooking clears the outputs
      if (pass.button_down && !btn_held && debounce_age > DEBOUNCE_MS) begin
         btn_held               = 1'b1;
         debounce_age           = '0;
         cooking                = ~cooking;
         outcome.beep_count     = outcome.beep_count + BEEPS_TOGGLE;
         buzzer                 = 1'b0;
         outcome.button_toggled = 1'b1;
         if (!cooking) begin
            fan   = 1'b0;
            valve = 1'b0;
         end
      end
      if (!pass.button_down)
         btn_held = 1'b0;

      if (!cooking) begin
         // protect mode: alert, then shut off once the alert persists
         if (last_gas > active_thr) begin
            if (!alerted) begin
               alerted            = 1'b1;
               alert_age          = '0;
               outcome.gas_event  = EVT_LEAK;
               outcome.beep_count = outcome.beep_count + BEEPS_LEAK;
               buzzer             = 1'b0;
            end
            if (alert_age > alarm_dly) begin
               trip_shutoff();
               outcome.gas_event = EVT_SHUTOFF;
            end
         end else if (alerted) begin
            alerted           = 1'b0;
            outcome.gas_event = EVT_NORMAL;
            buzzer            = 1'b0;
            valve             = 1'b0;
            fan               = 1'b0;
         end
      end else begin
         // cooking mode: quiet, fan with periodic beep, or emergency
         if (last_gas < normal_thr) begin
            fan    = 1'b0;
            buzzer = 1'b0;
         end else if (last_gas < high_thr) begin
            fan = 1'b1;
            if (beep_age > BEEP_PERIOD_MS) begin
               outcome.beep_count = outcome.beep_count + BEEPS_COOK;
               buzzer             = 1'b0;
               beep_age           = '0;
            end
         end else begin
            cooking = 1'b0;
            trip_shutoff();
            outcome.gas_event = EVT_COOK_EMG;
         end
      end

      outcome.valve_shut       = valve;
      outcome.fan_on           = fan;
      outcome.buzzer_on        = buzzer;
      outcome.cooking_now      = cooking;
      outcome.threshold_in_use = active_thr;
   endtask

   // ---------------------------------------------------------------- checking

   task automatic report_failure(input string msg);
      fail_count++;
      if (fail_count <= MAX_REPORTS)
         $display("[%0t] MISMATCH: %s", $realtime, msg);
   endtask

   task automatic check_field(input string name, input logic [15:0] want_v,
                              input logic [15:0] got_v);
      if (got_v !== want_v)
         report_failure($sformatf("result %0d %s expected %0d got %0d",
                                  results_seen, name, want_v, got_v));
   endtask

   // Check each response against the oldest prediction, then record new requests
   always @(posedge clock) begin
      rsp_payload_type want;
      rsp_payload_type got;
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen++;
         got = rsp_data;
         if (expected_passes.size() == 0) begin
            report_failure($sformatf("result %0d arrived with no request pending",
                                     results_seen));
         end else begin
            want = expected_passes.pop_front();
            check_field("valve_shut", want.valve_shut, got.valve_shut);
            check_field("fan_on", want.fan_on, got.fan_on);
            check_field("buzzer_on", want.buzzer_on, got.buzzer_on);
            check_field("cooking_now", want.cooking_now, got.cooking_now);
            check_field("gas_event", want.gas_event, got.gas_event);
            check_field("command_shutoff", want.command_shutoff, got.command_shutoff);
            check_field("beep_count", want.beep_count, got.beep_count);
            check_field("button_toggled", want.button_toggled, got.button_toggled);
            check_field("threshold_in_use", want.threshold_in_use,
                        got.threshold_in_use);
         end
         if (got.gas_event === EVT_LEAK)     leaks_seen++;
         if (got.gas_event === EVT_SHUTOFF)  shutoffs_seen++;
         if (got.gas_event === EVT_COOK_EMG) cook_emg_seen++;
         if (got.button_toggled === 1'b1)    toggles_seen++;
      end
      if (!reset && req_valid && req_ready) begin
         advance_interlock(req_data, want);
         expected_passes.push_back(want);
         passes_sent++;
      end
   end

   // Abort when nothing moves on either channel for too long
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("[%0t] watchdog: no request or response moved for %0d cycles",
                  $realtime, WATCHDOG_LIMIT);
         $display("Simulation FAILED");
         $finish;
      end
   end

   // Drive response ready: random idling, plus long stalls on request
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left--;
      end else if (holds_served != holds_asked) begin
         holds_served++;
         hold_left = HOLD_CYCLES - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   // ---------------------------------------------------------------- stimulus

   function automatic req_payload_type mk_pass(input int elapsed, input int gv,
                                               input int gas, input int tv,
                                               input int temp, input int btn,
                                               input int cmd);
      req_payload_type pass;
      pass.elapsed_ms  = 16'(elapsed);
      pass.gas_valid   = 1'(gv);
      pass.gas_sample  = 12'(gas);
      pass.temp_valid  = 1'(tv);
      pass.temp_sample = 8'(temp);
      pass.button_down = 1'(btn);
      pass.command     = 3'(cmd);
      return pass;
   endfunction

   // Offer one request and hold it until the block takes it
   task automatic send_pass(input req_payload_type pass);
      while ($urandom_range(99) < req_idle_pct) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= pass;
      do @(posedge clock); while (!req_ready);
   endtask

   // Drop valid and wait until every predicted response has come back
   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_passes.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [2:0] index, input logic [15:0] value);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= index;
      csr_wdata    <= value;
      case (index)
         REG_NORMAL_THR: normal_thr = value[11:0];
         REG_HIGH_THR:   high_thr   = value[11:0];
         REG_HOT_THR:    hot_thr    = value[11:0];
         REG_COLD_THR:   cold_thr   = value[11:0];
         REG_HOT_LIMIT:  hot_lim    = value[7:0];
         REG_COLD_LIMIT: cold_lim   = value[7:0];
         REG_ALARM_DLY:  alarm_dly  = value;
         default: ;
      endcase
      @(negedge clock);
      csr_write_en <= 1'b0;
   endtask

   task automatic write_all(input int nthr, input int hthr, input int hotthr,
                            input int coldthr, input int hlim, input int clim,
                            input int dly);
      wait_idle();
      write_reg(REG_NORMAL_THR, {4'h0, 12'(nthr)});
      write_reg(REG_HIGH_THR,   {4'h0, 12'(hthr)});
      write_reg(REG_HOT_THR,    {4'h0, 12'(hotthr)});
      write_reg(REG_COLD_THR,   {4'h0, 12'(coldthr)});
      write_reg(REG_HOT_LIMIT,  {8'h00, 8'(hlim)});
      write_reg(REG_COLD_LIMIT, {8'h00, 8'(clim)});
      write_reg(REG_ALARM_DLY,  16'(dly));
      settings_used++;
   endtask

   // Random pass: gas level and button level drift, commands are mostly none
   task automatic random_pass(output req_payload_type pass);
      int pick;
      int t;
      pick = $urandom_range(99);
      if (pick < 10)
         pass.elapsed_ms = '0;
      else if (pick < 65)
         pass.elapsed_ms = 16'($urandom_range(400));
      else if (pick < 92)
         pass.elapsed_ms = 16'($urandom_range(3500, 250));
      else
         pass.elapsed_ms = 16'($urandom);

      // move the gas level now and then, aiming around the thresholds
      if ($urandom_range(99) < 20) begin
         case ($urandom_range(4))
            0: gas_target = 12'($urandom_range(normal_thr));
            1: gas_target = 12'($urandom_range(high_thr, normal_thr));
            2: gas_target = 12'($urandom_range(4095, high_thr));
            3: gas_target = active_thr + 12'($urandom_range(2));
            default: gas_target = 12'($urandom);
         endcase
      end
      pass.gas_valid  = ($urandom_range(99) < 80);
      pass.gas_sample = ($urandom_range(99) < 5) ? 12'($urandom) : gas_target;

      pass.temp_valid = ($urandom_range(99) < 50);
      if ($urandom_range(99) < 85)
         t = int'($urandom_range(165)) - 40;
      else
         t = int'($urandom_range(255)) - 128;
      pass.temp_sample = 8'(t);

      if ($urandom_range(99) < 30)
         btn_level = ~btn_level;
      pass.button_down = btn_level;

      pass.command = ($urandom_range(99) < 75) ? CMD_NONE : 3'($urandom_range(7, 1));
   endtask

   // ---------------------------------------------------------------- tests

   // Protect mode: leak, persistence, shutoff, return to normal, field extremes
   task automatic test_protect_alarm();
      send_pass(mk_pass(0, 1, 0, 1, 25, 0, CMD_NONE));
      send_pass(mk_pass(100, 1, 4095, 0, 0, 0, CMD_NONE));
      send_pass(mk_pass(1500, 0, 0, 0, 0, 0, CMD_NONE));
      send_pass(mk_pass(600, 0, 0, 0, 0, 0, CMD_NONE));
      send_pass(mk_pass(0, 1, 0, 1, -40, 0, CMD_NONE));
      send_pass(mk_pass(65535, 1, 1000, 1, 125, 0, CMD_NONE));
   endtask

   // Every command code, including the unused ones
   task automatic test_remote_commands();
      for (int code = 0; code < 8; code++)
         send_pass(mk_pass(50, 1, 0, 0, 0, 0, code));
   endtask

   // Button debounce, cooking beep and cooking emergency
   task automatic test_button_and_cooking();
      send_pass(mk_pass(400, 1, 2000, 1, 25, 0, CMD_NONE));
      send_pass(mk_pass(100, 0, 0, 0, 0, 1, CMD_NONE));
      send_pass(mk_pass(500, 0, 0, 0, 0, 1, CMD_NONE));
      send_pass(mk_pass(0, 0, 0, 0, 0, 0, CMD_NONE));
      send_pass(mk_pass(100, 0, 0, 0, 0, 1, CMD_NONE));
      send_pass(mk_pass(100, 0, 0, 0, 0, 0, CMD_NONE));
      send_pass(mk_pass(100, 0, 0, 0, 0, 1, CMD_NONE));
      send_pass(mk_pass(0, 1, 4095, 0, 0, 0, CMD_NONE));
   endtask

   // High level at or below the normal level: cooking trips at the normal level
   task automatic test_crossed_levels();
      wait_idle();
      write_reg(REG_NORMAL_THR, 16'd2000);
      write_reg(REG_HIGH_THR, 16'd1500);
      send_pass(mk_pass(0, 1, 1800, 0, 0, 0, CMD_TOGGLE));
      send_pass(mk_pass(0, 1, 2000, 0, 0, 0, CMD_NONE));
   endtask

   // Random passes over several register settings, extremes first
   task automatic test_random_settings();
      req_payload_type pass;
      int nthr;
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: write_all(0, 0, 0, 0, -40, -40, 0);
            1: write_all(500, 4095, 4095, 0, 127, -128, 65535);
            2: write_all(4095, 0, 4095, 4095, 125, 125, 60000);
            default: begin
               nthr = $urandom_range(2500, 200);
               write_all(nthr, nthr + $urandom_range(1500, 100), $urandom_range(4095),
                         $urandom_range(4095), int'($urandom_range(165)) - 40,
                         int'($urandom_range(165)) - 40, $urandom_range(3000));
            end
         endcase
         // one whole phase runs with no idling on either side
         req_idle_pct = (phase == 4) ? 0 : 29;
         rsp_idle_pct = (phase == 4) ? 0 : 29;
         repeat (RANDOM_PER_PHASE) begin
            random_pass(pass);
            send_pass(pass);
         end
      end
      rsp_idle_pct = 29;
      req_idle_pct = 29;
   endtask

   // Long receiver stall while requests keep coming, so the block backs up
   task automatic test_backpressure();
      req_payload_type pass;
      holds_asked++;
      req_idle_pct = 0;
      repeat (40) begin
         random_pass(pass);
         send_pass(pass);
      end
      req_idle_pct = 29;
   endtask

   initial begin
      reset_interlock_model();
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_protect_alarm();
      test_remote_commands();
      test_button_and_cooking();
      test_crossed_levels();
      test_random_settings();
      test_backpressure();

      // drain, then give the pipeline a short tail
      wait_idle();
      repeat (10) @(posedge clock);
      if (expected_passes.size() != 0)
         report_failure($sformatf("%0d responses never arrived", expected_passes.size()));

      $display("Sent %0d control passes over %0d register settings, checked %0d responses",
               passes_sent, settings_used + 1, results_seen);
      $display("Saw %0d leaks, %0d safety shutoffs, %0d cooking emergencies, %0d toggles",
               leaks_seen, shutoffs_seen, cook_emg_seen, toggles_seen);
      if (fail_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
